### design/seven_segment_number_formatter_top_assert.svh
// ----------------------------------------------------------------------------
// Seven-segment formatter assertion macros
// Shared property templates for the formatter's port checker.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_NUMBER_FORMATTER_TOP_ASSERT_SVH
`define SEVEN_SEGMENT_NUMBER_FORMATTER_TOP_ASSERT_SVH

// same-cycle implication
`define SSNF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SSNF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/ssnf_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment formatter package
// Transaction types, segment codes and the digit glyph table.
// ----------------------------------------------------------------------------
package ssnf_pkg;

   localparam int DIGIT_COUNT_DEFAULT = 4;
   localparam int VALUE_WIDTH         = 32;
   localparam int BCD_DIGITS          = 10;  // enough for 2^32 - 1
   localparam int BCD_WIDTH           = 4 * BCD_DIGITS;
   localparam int STEP_WIDTH          = $clog2(VALUE_WIDTH);
   localparam int USED_WIDTH          = 4;   // holds up to BCD_DIGITS

   localparam logic [7:0] SEG_DOT  = 8'h80;
   localparam logic [7:0] SEG_DASH = 8'h40;
   localparam logic [1:0] PLACES_MAX = 2'd2;
   localparam logic [VALUE_WIDTH-1:0] VALUE_MOST_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic [1:0]                    decimal_places;
   } req_type;

   typedef struct packed {
      logic [7:0] digit_left;
      logic [7:0] digit_second;
      logic [7:0] digit_third;
      logic [7:0] digit_right;
      logic       changed;
      logic       unavailable;
   } rsp_type;

   // segments a..g in bits 0..6
   function automatic logic [7:0] glyph(input logic [3:0] digit);
      logic [7:0] seg;
      case (digit)
         4'd0: seg = 8'h3F;
         4'd1: seg = 8'h06;
         4'd2: seg = 8'h5B;
         4'd3: seg = 8'h4F;
         4'd4: seg = 8'h66;
         4'd5: seg = 8'h6D;
         4'd6: seg = 8'h7D;
         4'd7: seg = 8'h07;
         4'd8: seg = 8'h7F;
         4'd9: seg = 8'h6F;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

### design/seven_segment_number_formatter_top.sv
// ----------------------------------------------------------------------------
// Seven-segment number formatter
// Takes a signed 32-bit scaled value and a count of decimal places (0 to 2)
// and renders it right-aligned on DIGIT_COUNT seven-segment cells, with
// leading zeros up to the decimal point, the point in bit 7 and a minus sign
// left of the leftmost digit; dashes in every cell when it cannot be shown.
// The four rightmost cells are returned along with a flag saying whether
// the whole pattern differs from the last one shown. Each transaction runs
// one shift-and-add-3 binary-to-BCD step per cycle over the 32 value bits,
// then lays out the cells in a format state, which waits for as long as
// the previous result stays unread. The next request is taken once the
// result has moved into the output register and the block is idle again,
// and one can be accepted while the previous result still waits.
// ----------------------------------------------------------------------------
module seven_segment_number_formatter_top
   import ssnf_pkg::*;
#(
   parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int PATTERN_WIDTH = 8 * DIGIT_COUNT;
   localparam logic [USED_WIDTH-1:0] CELLS = USED_WIDTH'(DIGIT_COUNT);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_FORMAT
   } state_type;

   state_type                state_ff, state_in;
   logic [VALUE_WIDTH-1:0]   mag_ff, mag_in;
   logic [BCD_WIDTH-1:0]     bcd_ff, bcd_in;
   logic [STEP_WIDTH-1:0]    step_ff, step_in;
   logic                     neg_ff, neg_in;
   logic                     bad_ff, bad_in;
   logic [1:0]               places_ff, places_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;
   logic [PATTERN_WIDTH-1:0] shown_ff, shown_in;

   logic [BCD_WIDTH-1:0]     bcd_adj;
   logic [USED_WIDTH-1:0]    mag_digits;
   logic [USED_WIDTH-1:0]    used;
   logic                     fit;
   logic [PATTERN_WIDTH-1:0] pattern;
   logic [7:0]               field [4];
   logic [VALUE_WIDTH-1:0]   raw;

   // add-3 correction of each BCD digit before the shift
   always_comb begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   // layout of the cells from the finished BCD digits
   always_comb begin
      mag_digits = USED_WIDTH'(1);
      for (int d = 1; d < BCD_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] != 4'd0) begin
            mag_digits = USED_WIDTH'(d + 1);
         end
      end
      if (mag_digits > USED_WIDTH'(places_ff) + USED_WIDTH'(1)) begin
         used = mag_digits;
      end else begin
         used = USED_WIDTH'(places_ff) + USED_WIDTH'(1);
      end
      // a negative number also needs a free cell for the sign
      fit = !bad_ff && (used <= CELLS) && !(neg_ff && (used == CELLS));

      for (int i = 0; i < DIGIT_COUNT; i++) begin
         // DIGIT_COUNT - 1 - i counts cells from the right
         if (!fit) begin
            pattern[8*i +: 8] = SEG_DASH;
         end else if (USED_WIDTH'(DIGIT_COUNT - 1 - i) < used) begin
            pattern[8*i +: 8] = glyph(bcd_ff[4*(DIGIT_COUNT-1-i) +: 4]);
            if ((places_ff != 2'd0) &&
                (USED_WIDTH'(DIGIT_COUNT - 1 - i) == USED_WIDTH'(places_ff))) begin
               pattern[8*i +: 8] = pattern[8*i +: 8] | SEG_DOT;
            end
         end else if (neg_ff && (USED_WIDTH'(DIGIT_COUNT - 1 - i) == used)) begin
            pattern[8*i +: 8] = SEG_DASH;
         end else begin
            pattern[8*i +: 8] = 8'h00;
         end
      end

      // the four rightmost cells; cells left of cell 0 read as blank
      for (int k = 0; k < 4; k++) begin
         if (DIGIT_COUNT - 4 + k >= 0) begin
            field[k] = pattern[8*((DIGIT_COUNT - 4 + k >= 0) ? DIGIT_COUNT - 4 + k : 0) +: 8];
         end else begin
            field[k] = 8'h00;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      bad_in       = bad_ff;
      places_in    = places_ff;
      rsp_data_in  = rsp_data_ff;
      shown_in     = shown_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      raw          = req_data.value;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mag_in    = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
               neg_in    = raw[VALUE_WIDTH-1];
               bad_in    = (req_data.decimal_places > PLACES_MAX) || (raw == VALUE_MOST_NEG);
               places_in = req_data.decimal_places;
               bcd_in    = '0;
               step_in   = '0;
               state_in  = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in  = {bcd_adj[BCD_WIDTH-2:0], mag_ff[VALUE_WIDTH-1]};
            mag_in  = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_WIDTH'(VALUE_WIDTH - 1)) begin
               state_in = ST_FORMAT;
            end
         end
         ST_FORMAT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.digit_left   = field[0];
               rsp_data_in.digit_second = field[1];
               rsp_data_in.digit_third  = field[2];
               rsp_data_in.digit_right  = field[3];
               rsp_data_in.changed      = (pattern != shown_ff);
               rsp_data_in.unavailable  = !fit;
               rsp_valid_in             = 1'b1;
               shown_in                 = pattern;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      step_ff     <= step_in;
      neg_ff      <= neg_in;
      bad_ff      <= bad_in;
      places_ff   <= places_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         shown_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         shown_ff     <= shown_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### design/ssnf_checker.sv
// ----------------------------------------------------------------------------
// Seven-segment formatter port checker
// Watches the formatter's ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "seven_segment_number_formatter_top_assert.svh"

module ssnf_checker
   import ssnf_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result must stay put
   `SSNF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // converter is busy right after taking a transaction
   `SSNF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "request taken while converting")

   `SSNF_ASSERT_IMPLY(a_dash_when_unavailable, clock, reset, rsp_valid && rsp_data.unavailable, rsp_data.digit_right == SEG_DASH, "unavailable without dash")

   // rightmost cell always holds a digit and never the point
   `SSNF_ASSERT_IMPLY(a_right_digit, clock, reset, rsp_valid && !rsp_data.unavailable, (rsp_data.digit_right != 8'h00) && !rsp_data.digit_right[7], "rightmost cell not a digit")

endmodule

bind seven_segment_number_formatter_top ssnf_checker u_ssnf_checker (.*);
